FILE: rtl/core/mtf_pkg.sv
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int SYM_W        = 8;
  localparam int NUM_SLOTS    = 256;
  localparam int LEN_W        = 9;
  localparam int ALPHABET_MAX = 256;
  localparam int GROUP_SIZE   = 16;
  localparam int NUM_GROUPS   = NUM_SLOTS / GROUP_SIZE;
  localparam int LOC_W        = $clog2(GROUP_SIZE);
  localparam int GRP_W        = SYM_W - LOC_W;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CODE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DUP    = 2'd3
  } status_t;

  typedef struct packed {
    logic             by_index;
    logic             append;
    logic             shift;
    logic [SYM_W-1:0] key;
    logic [SYM_W-1:0] pos;
    logic [LEN_W-1:0] length;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/mtf_cell.sv
`timescale 1ns / 1ps

module mtf_cell (
  input  logic                     clk,
  input  mtf_pkg::cell_ctrl_t      ctrl,
  input  logic [mtf_pkg::SYM_W-1:0] slot,
  input  logic [mtf_pkg::SYM_W-1:0] prev_sym,
  output logic [mtf_pkg::SYM_W-1:0] sym,
  output logic                     match
);
  import mtf_pkg::*;

  logic valid;

  assign valid = {1'b0, slot} < ctrl.length;

  always_ff @(posedge clk) begin
    match <= valid && (ctrl.by_index ? (slot == ctrl.key) : (sym == ctrl.key));
    if (ctrl.append && ({1'b0, slot} == ctrl.length)) begin
      sym <= ctrl.key;
    end else if (ctrl.shift && (slot <= ctrl.pos)) begin
      sym <= prev_sym;
    end
  end

endmodule

FILE: rtl/core/mtf_group.sv
`timescale 1ns / 1ps

module mtf_group (
  input  logic                                            clk,
  input  logic [mtf_pkg::GRP_W-1:0]                       grp,
  input  logic [mtf_pkg::GROUP_SIZE-1:0]                  match,
  input  logic [mtf_pkg::GROUP_SIZE-1:0][mtf_pkg::SYM_W-1:0] syms,
  output logic                                            hit,
  output logic [mtf_pkg::SYM_W-1:0]                       sym,
  output logic [mtf_pkg::SYM_W-1:0]                       idx
);
  import mtf_pkg::*;

  logic [SYM_W-1:0] sym_or;
  logic [LOC_W-1:0] loc_or;

  always_comb begin
    sym_or = '0;
    loc_or = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (match[i]) begin
        sym_or = sym_or | syms[i];
        loc_or = loc_or | LOC_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    hit <= |match;
    sym <= sym_or;
    idx <= {grp, loc_or};
  end

endmodule

FILE: rtl/core/move_to_front_codec_top.sv
// Each word steps through match in the cell row, a registered group reduction,
// a final fold, then the shift through the cell row; a new word is taken only
// once the last one is through. Apply waits while a result is not yet taken.
// A new word is taken while a finished result still waits on the output.
// Reset (rst, synchronous): list length 0, mode encode; list contents stay.
`timescale 1ns / 1ps

module move_to_front_codec_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // value[7:0]
  input  logic [1:0] s_tuser,   // op[1:0]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // result_value[7:0]
  output logic [1:0] m_tuser    // status[1:0]
);
  import mtf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_GROUP,
    S_FOLD,
    S_APPLY
  } state_t;

  state_t           state;
  logic             mode;
  logic [LEN_W-1:0] length;
  logic [1:0]       op_q;
  logic [SYM_W-1:0] value_q;
  logic             found;
  logic [SYM_W-1:0] found_pos;
  logic [SYM_W-1:0] found_sym;

  cell_ctrl_t ctrl;

  logic [NUM_SLOTS-1:0]            match_all;
  logic [NUM_SLOTS-1:0][SYM_W-1:0] sym_all;
  logic [NUM_GROUPS-1:0]           grp_hit;
  logic [NUM_GROUPS-1:0][SYM_W-1:0] grp_sym;
  logic [NUM_GROUPS-1:0][SYM_W-1:0] grp_idx;

  logic             fold_hit;
  logic [SYM_W-1:0] fold_sym;
  logic [SYM_W-1:0] fold_idx;

  logic             apply;
  logic             is_full;
  logic             pos_range;
  logic [SYM_W-1:0] res_next;
  status_t          st_next;
  logic             do_append;
  logic             do_shift;
  logic [LEN_W-1:0] length_next;

  assign s_tready = (state == S_IDLE);
  assign apply    = (state == S_APPLY) && (!m_tvalid || m_tready);

  assign ctrl.by_index = (op_q == OP_CODE) && mode;
  assign ctrl.append   = apply && do_append;
  assign ctrl.shift    = apply && do_shift;
  assign ctrl.key      = value_q;
  assign ctrl.pos      = found_pos;
  assign ctrl.length   = length;

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    for (genvar c = 0; c < GROUP_SIZE; c++) begin : g_cell
      localparam int Idx = g * GROUP_SIZE + c;
      logic [SYM_W-1:0] prev;
      if (Idx == 0) begin : g_head
        assign prev = found_sym;
      end else begin : g_link
        assign prev = sym_all[Idx-1];
      end
      mtf_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .slot     (SYM_W'(Idx)),
        .prev_sym (prev),
        .sym      (sym_all[Idx]),
        .match    (match_all[Idx])
      );
    end
    mtf_group u_group (
      .clk   (clk),
      .grp   (GRP_W'(g)),
      .match (match_all[g*GROUP_SIZE +: GROUP_SIZE]),
      .syms  (sym_all[g*GROUP_SIZE +: GROUP_SIZE]),
      .hit   (grp_hit[g]),
      .sym   (grp_sym[g]),
      .idx   (grp_idx[g])
    );
  end

  always_comb begin
    fold_hit = |grp_hit;
    fold_sym = '0;
    fold_idx = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (grp_hit[g]) begin
        fold_sym = fold_sym | grp_sym[g];
        fold_idx = fold_idx | grp_idx[g];
      end
    end
  end

  assign is_full   = length >= LEN_W'(ALPHABET_MAX);
  assign pos_range = {1'b0, value_q} >= length;

  always_comb begin
    res_next    = '0;
    st_next     = ST_OK;
    do_append   = 1'b0;
    do_shift    = 1'b0;
    length_next = length;
    case (op_q)
      OP_CLEAR: begin
        length_next = '0;
      end
      OP_LOAD: begin
        if (found) begin
          st_next = ST_DUP;
        end else if (is_full) begin
          st_next = ST_RANGE;
        end else begin
          res_next    = length[SYM_W-1:0];
          do_append   = 1'b1;
          length_next = length + LEN_W'(1);
        end
      end
      OP_CODE: begin
        if (!mode) begin
          if (!found) begin
            st_next = ST_ABSENT;
          end else begin
            res_next = found_pos;
            do_shift = 1'b1;
          end
        end else begin
          if (pos_range) begin
            st_next = ST_RANGE;
          end else begin
            res_next = found_sym;
            do_shift = 1'b1;
          end
        end
      end
      default: begin
        st_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= 1'b0;
      length   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (apply) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: state <= S_GROUP;
        S_GROUP: state <= S_FOLD;
        S_FOLD:  state <= S_APPLY;
        S_APPLY: begin
          if (apply) begin
            state  <= S_IDLE;
            length <= length_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q    <= s_tuser;
      value_q <= s_tdata;
    end
    if (state == S_FOLD) begin
      found     <= fold_hit;
      found_pos <= fold_idx;
      found_sym <= fold_sym;
    end
    if (apply) begin
      m_tdata <= res_next;
      m_tuser <= st_next;
    end
  end

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_W'(ALPHABET_MAX))
    else $error("list length above alphabet size");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (apply && op_q == OP_CLEAR) |=> (length == '0))
    else $error("clear did not empty the list");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_APPLY))
    else $error("result raised outside apply");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_MATCH && !s_tready))
    else $error("accepted word did not enter match");

  a_shift_found: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift |-> (found && !ctrl.append))
    else $error("shift without a matched entry");

endmodule

FILE: bench/move_to_front_codec_top_test.sv
`timescale 1ns / 1ps

module move_to_front_codec_top_test;
  import mtf_pkg::*;

  localparam int LIMIT_CYCLES = 600000;

  typedef struct {
    op_t        op;
    logic [7:0] value;
  } word_t;

  typedef struct {
    logic [7:0] value;
    status_t    status;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;

  move_to_front_codec_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  sym_order [256];
  int          order_len = 0;
  logic        coder_mode = 1'b0;

  // stimulus bookkeeping
  word_t       queued_words[$];
  outcome_t    due_results[$];
  logic [7:0]  gen_syms [256];
  logic [7:0]  perm [256];
  logic [255:0] gen_set;
  int          gen_len = 0;
  int          word_total = 0;
  int          phase_cnt = 0;
  int          checked = 0;
  int          fails = 0;
  int          cycles = 0;

  function automatic void move_front(int p);
    logic [7:0] s;
    int k;
    s = sym_order[p];
    for (k = p; k > 0; k--) sym_order[k] = sym_order[k-1];
    sym_order[0] = s;
  endfunction

  function automatic outcome_t mtf_apply(op_t op, logic [7:0] v);
    outcome_t r;
    int hit;
    int i;
    r.value = '0;
    r.status = ST_OK;
    hit = -1;
    for (i = 0; i < order_len; i++)
      if (hit < 0 && sym_order[i] == v) hit = i;
    case (op)
      OP_CLEAR: order_len = 0;
      OP_LOAD: begin
        if (hit >= 0) begin
          r.status = ST_DUP;
        end else if (order_len >= ALPHABET_MAX) begin
          r.status = ST_RANGE;
        end else begin
          sym_order[order_len] = v;
          r.value = order_len[7:0];
          order_len++;
        end
      end
      OP_CODE: begin
        if (!coder_mode) begin
          if (hit < 0) begin
            r.status = ST_ABSENT;
          end else begin
            r.value = hit[7:0];
            move_front(hit);
          end
        end else if (int'(v) >= order_len) begin
          r.status = ST_RANGE;
        end else begin
          r.value = sym_order[v];
          move_front(int'(v));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  word_t nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        due_results = {due_results, mtf_apply(op_t'(s_tuser), s_tdata)};
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (queued_words.size() > 0) begin
          nxt = queued_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.value;
          s_tuser <= nxt.op;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result and stalls at a randomly redrawn rate
  int stall_pct = 0;
  outcome_t exp_r;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: result_value %0d status %0d", m_tdata, m_tuser);
          fails++;
        end else begin
          exp_r = due_results.pop_front();
          checked++;
          if (m_tdata !== exp_r.value) begin
            $error("result_value: expected %0d, got %0d", exp_r.value, m_tdata);
            fails++;
          end
          if (m_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
            fails++;
          end
        end
      end
      if (cycles % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("move_to_front_codec_top verification failed");
      $finish;
    end
  end

  task automatic push_word(op_t op, logic [7:0] v);
    word_t w;
    w.op = op;
    w.value = v;
    queued_words = {queued_words, w};
    word_total++;
  endtask

  task automatic settle();
    while (queued_words.size() != 0 || s_tvalid || due_results.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_mode(logic m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    coder_mode = m;
  endtask

  // clear, then load the first alph symbols of a shuffled byte range, with occasional duplicate loads
  task automatic restock(int alph);
    int i;
    int j;
    logic [7:0] t;
    push_word(OP_CLEAR, 8'($urandom_range(0, 255)));
    for (i = 0; i < 256; i++) perm[i] = i[7:0];
    for (i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    gen_set = '0;
    gen_len = 0;
    for (i = 0; i < alph; i++) begin
      push_word(OP_LOAD, perm[i]);
      gen_syms[i] = perm[i];
      gen_set[perm[i]] = 1'b1;
      gen_len++;
      if (i > 0 && $urandom_range(0, 7) == 0) push_word(OP_LOAD, gen_syms[$urandom_range(0, i)]);
    end
  endtask

  task automatic gen_phase(logic m, int alph, int n);
    int k;
    int r;
    logic [7:0] v;
    restock(alph);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        v = m ? 8'($urandom_range(0, gen_len - 1)) : gen_syms[$urandom_range(0, gen_len - 1)];
        push_word(OP_CODE, v);
      end else if (r < 86) begin
        push_word(OP_CODE, 8'($urandom_range(0, 255)));
      end else if (r < 90) begin
        v = 8'($urandom_range(0, 255));
        push_word(OP_LOAD, v);
        if (!gen_set[v] && gen_len < 256) begin
          gen_set[v] = 1'b1;
          gen_syms[gen_len] = v;
          gen_len++;
        end
      end else if (r < 94) begin
        push_word(OP_LOAD, gen_syms[$urandom_range(0, gen_len - 1)]);
      end else if (r < 97 || alph > 80) begin
        push_word(OP_NONE, 8'($urandom_range(0, 255)));
      end else begin
        restock(alph);
      end
    end
  endtask

  logic pm;
  int   alph;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // encode after reset: empty list, loads, duplicate, moves, absent symbol
    push_word(OP_CODE, 8'h10);
    push_word(OP_LOAD, 8'h00);
    push_word(OP_LOAD, 8'hFF);
    push_word(OP_LOAD, 8'hA5);
    push_word(OP_LOAD, 8'h5A);
    push_word(OP_LOAD, 8'hFF);
    push_word(OP_CODE, 8'h5A);
    push_word(OP_CODE, 8'h5A);
    push_word(OP_CODE, 8'h00);
    push_word(OP_CODE, 8'h33);
    push_word(OP_NONE, 8'hFF);
    push_word(OP_CLEAR, 8'h00);
    settle();

    // decode: empty list, moves, positions past the end
    set_mode(1'b1);
    push_word(OP_CODE, 8'h00);
    push_word(OP_LOAD, 8'h80);
    push_word(OP_LOAD, 8'h01);
    push_word(OP_LOAD, 8'h7F);
    push_word(OP_CODE, 8'h02);
    push_word(OP_CODE, 8'h02);
    push_word(OP_CODE, 8'h03);
    push_word(OP_CODE, 8'hFF);
    push_word(OP_NONE, 8'h00);
    push_word(OP_CLEAR, 8'hFF);
    settle();

    while (word_total < 1600 || phase_cnt < 6) begin
      pm = phase_cnt[0];
      set_mode(pm);
      if (phase_cnt == 2 || phase_cnt == 5) begin
        gen_phase(pm, 256, 100);
        push_word(OP_LOAD, 8'($urandom_range(0, 255)));
      end else begin
        alph = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 80) : $urandom_range(2, 24);
        gen_phase(pm, alph, $urandom_range(60, 180));
      end
      phase_cnt++;
      settle();
    end

    $display("Sent %0d words over %0d random phases plus directed cases; %0d results checked.",
             word_total, phase_cnt, checked);
    $display("Both modes, alphabets of 2 to 256 symbols, clears, duplicates, misses, unused op.");
    if (fails == 0) begin
      $display("move_to_front_codec_top verification clean");
    end else begin
      $display("move_to_front_codec_top verification failed");
    end
    $finish;
  end

endmodule
